// File: sv/psd_pkg.sv
package psd_pkg;

  localparam int unsigned CoordBits     = 24;
  localparam int unsigned ParamFracBits = 16;
  localparam int unsigned CfgBits       = 16;
  localparam int unsigned DistBits      = 52;

endpackage

// File: sv/psd_front.sv
// Front end. It forms the differences, squares them, and sums the dot product and the lengths.
// Stage 1 registers the differences. Stage 2 registers the nine products.
// Stage 3 registers the sums and the degenerate compare.
module psd_front #(
  parameter int unsigned CB = psd_pkg::CoordBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [psd_pkg::CfgBits-1:0]      min_length_i,
  input  logic signed [3*CB-1:0]           p_i,
  input  logic signed [3*CB-1:0]           s_i,
  input  logic signed [3*CB-1:0]           e_i,
  output logic                             vld_o,
  output logic signed [3*(CB+1)-1:0]       v_o,
  output logic signed [3*(CB+1)-1:0]       d_o,
  output logic signed [2*CB+4:0]           dot_o,
  output logic [2*CB+3:0]                  len2_o,
  output logic [2*CB+3:0]                  vlen2_o,
  output logic                             degen_o
);
  import psd_pkg::*;

  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 2;

  logic signed [DW-1:0] v1_q [3];
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] v2_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [DW-1:0] v3_q [3];
  logic signed [DW-1:0] d3_q [3];
  logic signed [PW-1:0] pvd_q [3];
  logic [PW-1:0]        pdd_q [3];
  logic [PW-1:0]        pvv_q [3];
  logic [2*CfgBits-1:0] thr_q;
  logic                 vld1_q, vld2_q, vld3_q;
  logic signed [SW-1:0] dot_q;
  logic [SW-1:0]        len2_q, vlen2_q;
  logic                 degen_q;
  logic [SW-1:0]        len2_d;

  always_comb begin
    len2_d = SW'(pdd_q[0]) + SW'(pdd_q[1]) + SW'(pdd_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i]  <= DW'($signed(p_i[i*CB +: CB])) - DW'($signed(s_i[i*CB +: CB]));
        d1_q[i]  <= DW'($signed(e_i[i*CB +: CB])) - DW'($signed(s_i[i*CB +: CB]));
        v2_q[i]  <= v1_q[i];
        d2_q[i]  <= d1_q[i];
        v3_q[i]  <= v2_q[i];
        d3_q[i]  <= d2_q[i];
        pvd_q[i] <= PW'(v1_q[i]) * PW'(d1_q[i]);
        pdd_q[i] <= PW'(PW'(d1_q[i]) * PW'(d1_q[i]));
        pvv_q[i] <= PW'(PW'(v1_q[i]) * PW'(v1_q[i]));
      end
      thr_q   <= (2*CfgBits)'(min_length_i) * (2*CfgBits)'(min_length_i);
      dot_q   <= SW'(pvd_q[0]) + SW'(pvd_q[1]) + SW'(pvd_q[2]);
      len2_q  <= len2_d;
      vlen2_q <= SW'(pvv_q[0]) + SW'(pvv_q[1]) + SW'(pvv_q[2]);
      degen_q <= len2_d <= SW'(thr_q);
    end
  end

  assign vld_o   = vld3_q;
  assign v_o     = {v3_q[2], v3_q[1], v3_q[0]};
  assign d_o     = {d3_q[2], d3_q[1], d3_q[0]};
  assign dot_o   = (SW+1)'(dot_q);
  assign len2_o  = len2_q;
  assign vlen2_o = vlen2_q;
  assign degen_o = degen_q;

endmodule

// File: sv/psd_div.sv
// Pipelined restoring divider that produces one quotient bit per stage.
// It clamps t to the range 0..1 and carries the side data alongside.
module psd_div #(
  parameter int unsigned CB = psd_pkg::CoordBits,
  parameter int unsigned FB = psd_pkg::ParamFracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic signed [3*(CB+1)-1:0] v_i,
  input  logic signed [3*(CB+1)-1:0] d_i,
  input  logic signed [2*CB+4:0]     dot_i,
  input  logic [2*CB+3:0]            len2_i,
  input  logic [2*CB+3:0]            vlen2_i,
  input  logic                       degen_i,
  output logic                       vld_o,
  output logic signed [3*(CB+1)-1:0] v_o,
  output logic signed [3*(CB+1)-1:0] d_o,
  output logic [FB:0]                t_o,
  output logic [2*CB+3:0]            vlen2_o,
  output logic                       degen_o
);
  import psd_pkg::*;

  localparam int unsigned SW = 2 * CB + 4;
  localparam int unsigned N  = FB + 1;

  typedef struct packed {
    logic                       vld;
    logic                       degen;
    logic                       lo;
    logic                       hi;
    logic [SW:0]                rem;
    logic [SW-1:0]              den;
    logic [FB-1:0]              q;
    logic signed [3*(CB+1)-1:0] v;
    logic signed [3*(CB+1)-1:0] d;
    logic [SW-1:0]              vlen2;
  } div_stage_t;

  div_stage_t st_q [N];
  div_stage_t st_d [N];

  always_comb begin
    st_d[0].vld   = vld_i;
    st_d[0].degen = degen_i;
    st_d[0].lo    = dot_i <= 0;
    st_d[0].hi    = !(dot_i <= 0) && (SW'(dot_i) >= len2_i);
    st_d[0].rem   = (SW+1)'(SW'(dot_i));
    st_d[0].den   = len2_i;
    st_d[0].q     = '0;
    st_d[0].v     = v_i;
    st_d[0].d     = d_i;
    st_d[0].vlen2 = vlen2_i;
    for (int k = 1; k < N; k++) begin
      logic [SW+1:0] sh;
      sh = {st_q[k-1].rem, 1'b0};
      st_d[k] = st_q[k-1];
      if (sh >= (SW+2)'(st_q[k-1].den)) begin
        st_d[k].rem = (SW+1)'(sh - (SW+2)'(st_q[k-1].den));
        st_d[k].q   = {st_q[k-1].q[FB-2:0], 1'b1};
      end else begin
        st_d[k].rem = (SW+1)'(sh);
        st_d[k].q   = {st_q[k-1].q[FB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) st_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < N; k++) st_q[k] <= st_d[k];
    end
  end

  always_comb begin
    if (st_q[N-1].degen || st_q[N-1].lo) begin
      t_o = '0;
    end else if (st_q[N-1].hi) begin
      t_o = {1'b1, {FB{1'b0}}};
    end else begin
      t_o = {1'b0, st_q[N-1].q};
    end
  end

  assign vld_o   = st_q[N-1].vld;
  assign v_o     = st_q[N-1].v;
  assign d_o     = st_q[N-1].d;
  assign vlen2_o = st_q[N-1].vlen2;
  assign degen_o = st_q[N-1].degen;

endmodule

// File: sv/psd_back.sv
// Back end. It forms the residuals, squares them and sums them; a degenerate segment gives |v|^2 instead.
// Stage 1 registers the t*d products. Stage 2 registers the rounded residuals.
// Stage 3 registers the squares. Stage 4 registers the sum.
module psd_back #(
  parameter int unsigned CB = psd_pkg::CoordBits,
  parameter int unsigned FB = psd_pkg::ParamFracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic signed [3*(CB+1)-1:0]       v_i,
  input  logic signed [3*(CB+1)-1:0]       d_i,
  input  logic [FB:0]                      t_i,
  input  logic [2*CB+3:0]                  vlen2_i,
  input  logic                             degen_i,
  output logic                             vld_o,
  output logic [psd_pkg::DistBits-1:0]     dist_o,
  output logic [FB:0]                      t_o,
  output logic                             degen_o
);
  import psd_pkg::*;

  localparam int unsigned DW = CB + 1;
  localparam int unsigned XW = DW + FB + 2;
  localparam int unsigned RW = XW - FB;
  localparam int unsigned QW = 2 * RW;
  localparam int unsigned SW = 2 * CB + 4;

  logic signed [DW-1:0] v1_q [3];
  logic signed [XW-1:0] td1_q [3];
  logic signed [RW-1:0] r2_q [3];
  logic [QW-1:0]        sq3_q [3];
  logic [FB:0]          t1_q, t2_q, t3_q, t4_q;
  logic [SW-1:0]        vl1_q, vl2_q, vl3_q;
  logic [3:0]           vld_q;
  logic [3:0]           dg_q;
  logic [DistBits-1:0]  dist_q;
  logic signed [XW-1:0] x_d [3];
  logic [QW+1:0]        sum_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_d[i] = (XW'(v1_q[i]) <<< FB) - td1_q[i] + XW'(1 << (FB - 1));
    end
    sum_d = (QW+2)'(sq3_q[0]) + (QW+2)'(sq3_q[1]) + (QW+2)'(sq3_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i]  <= v_i[i*DW +: DW];
        td1_q[i] <= XW'($signed({1'b0, t_i})) * XW'($signed(d_i[i*DW +: DW]));
        r2_q[i]  <= RW'(x_d[i] >>> FB);
        sq3_q[i] <= QW'(QW'(r2_q[i]) * QW'(r2_q[i]));
      end
      dg_q   <= {dg_q[2:0], degen_i};
      t1_q   <= t_i;
      t2_q   <= t1_q;
      t3_q   <= t2_q;
      t4_q   <= t3_q;
      vl1_q  <= vlen2_i;
      vl2_q  <= vl1_q;
      vl3_q  <= vl2_q;
      dist_q <= dg_q[2] ? DistBits'(vl3_q) : DistBits'(sum_d);
    end
  end

  assign vld_o   = vld_q[3];
  assign dist_o  = dist_q;
  assign t_o     = t4_q;
  assign degen_o = dg_q[3];

endmodule

// File: sv/point_segment_distance_sq_3d.sv
// Throughput: one transaction per cycle unless stalled.
// The divider has an entry stage and then one stage per quotient bit.
// A stall on a valid output holds every stage, and the input is stalled with it.
// The input stalls whenever a finished result is held, even if bubbles remain.
// Reset clears all valid bits and sets min_length to 0.
module point_segment_distance_sq_3d #(
  parameter int unsigned COORD_BITS      = psd_pkg::CoordBits,
  parameter int unsigned PARAM_FRAC_BITS = psd_pkg::ParamFracBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psd_pkg::CfgBits-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic signed [COORD_BITS-1:0]      point_z_i,
  input  logic signed [COORD_BITS-1:0]      seg_start_x_i,
  input  logic signed [COORD_BITS-1:0]      seg_start_y_i,
  input  logic signed [COORD_BITS-1:0]      seg_start_z_i,
  input  logic signed [COORD_BITS-1:0]      seg_end_x_i,
  input  logic signed [COORD_BITS-1:0]      seg_end_y_i,
  input  logic signed [COORD_BITS-1:0]      seg_end_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [psd_pkg::DistBits-1:0]      dist_squared_o,
  output logic [PARAM_FRAC_BITS:0]          param_t_o,
  output logic                              degenerate_o
);
  import psd_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * COORD_BITS + 4;

  logic [CfgBits-1:0]    min_length_q;
  logic                  en;
  logic                  f_vld, d_vld, f_dg, d_dg;
  logic signed [3*DW-1:0] f_v, f_d, d_v, d_d;
  logic signed [SW:0]    f_dot;
  logic [SW-1:0]         f_len2, f_vl2, d_vl2;
  logic [PARAM_FRAC_BITS:0] d_t;

  // The whole pipeline advances unless a finished result is held by the stall.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= '0;
    end else if (cfg_we_i) begin
      min_length_q <= cfg_wdata_i;
    end
  end

  psd_front #(.CB(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .min_length_i(min_length_q),
    .p_i({point_z_i, point_y_i, point_x_i}),
    .s_i({seg_start_z_i, seg_start_y_i, seg_start_x_i}),
    .e_i({seg_end_z_i, seg_end_y_i, seg_end_x_i}),
    .vld_o(f_vld), .v_o(f_v), .d_o(f_d), .dot_o(f_dot), .len2_o(f_len2),
    .vlen2_o(f_vl2), .degen_o(f_dg)
  );

  psd_div #(.CB(COORD_BITS), .FB(PARAM_FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .v_i(f_v), .d_i(f_d), .dot_i(f_dot),
    .len2_i(f_len2), .vlen2_i(f_vl2), .degen_i(f_dg),
    .vld_o(d_vld), .v_o(d_v), .d_o(d_d), .t_o(d_t), .vlen2_o(d_vl2), .degen_o(d_dg)
  );

  psd_back #(.CB(COORD_BITS), .FB(PARAM_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(d_vld), .v_i(d_v), .d_i(d_d), .t_i(d_t),
    .vlen2_i(d_vl2), .degen_i(d_dg),
    .vld_o(out_valid_o), .dist_o(dist_squared_o), .t_o(param_t_o),
    .degen_o(degenerate_o)
  );

  a_deg_t0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> param_t_o == '0)
    else $error("degenerate result with nonzero t");
  a_t_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> param_t_o <= (PARAM_FRAC_BITS+1)'(1 << PARAM_FRAC_BITS))
    else $error("t out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dist_squared_o))
    else $error("stalled result changed");

endmodule
